/* sv/tarc_pkg.sv */
`timescale 1ns / 1ps

package tarc_pkg;

    // arctangent iteration count, capped at the table length
    localparam int ANGLE_ITERATIONS = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int TARC_ITERS       = (ANGLE_ITERATIONS < ATAN_ENTRIES) ?
                                      ANGLE_ITERATIONS : ATAN_ENTRIES;
    localparam int ITER_W           = $clog2(TARC_ITERS);
    localparam int TBL_W            = $clog2(ATAN_ENTRIES);

    // field widths
    localparam int ACC_IN_W = 16;
    localparam int ANGLE_W  = 10;
    localparam int THR_A_W  = 11;
    localparam int FORCE_W  = 12;
    localparam int REP_W    = 16;
    localparam int SEQ_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;

    // datapath widths
    localparam int PRE_SHIFT = 14;
    localparam int XY_W      = 33;
    localparam int ACC_W     = 28;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX = ANGLE_W'(900);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOW_ANGLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_ANGLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_THR  = 2'd2;

    // register reset values
    localparam logic [THR_A_W-1:0] RST_LOW_ANGLE  = 11'd350;
    localparam logic [THR_A_W-1:0] RST_HIGH_ANGLE = 11'd700;
    localparam logic [FORCE_W-1:0] RST_FORCE_THR  = 12'd150;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_WRAP = 3'b100
    } t_state;

    // atan(2^-i) in tenths of a degree, Q16
    function automatic logic signed [ACC_W-1:0] tarc_atan(input logic [TBL_W-1:0] idx);
        logic signed [ACC_W-1:0] v;
        begin
            case (idx)
                5'd0:    v = 28'sd29491200;
                5'd1:    v = 28'sd17409672;
                5'd2:    v = 28'sd9198793;
                5'd3:    v = 28'sd4669451;
                5'd4:    v = 28'sd2343786;
                5'd5:    v = 28'sd1173036;
                5'd6:    v = 28'sd586661;
                5'd7:    v = 28'sd293348;
                5'd8:    v = 28'sd146676;
                5'd9:    v = 28'sd73339;
                5'd10:   v = 28'sd36669;
                5'd11:   v = 28'sd18335;
                5'd12:   v = 28'sd9167;
                5'd13:   v = 28'sd4584;
                5'd14:   v = 28'sd2292;
                5'd15:   v = 28'sd1146;
                5'd16:   v = 28'sd573;
                5'd17:   v = 28'sd286;
                5'd18:   v = 28'sd143;
                5'd19:   v = 28'sd72;
                5'd20:   v = 28'sd36;
                5'd21:   v = 28'sd18;
                5'd22:   v = 28'sd9;
                5'd23:   v = 28'sd4;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

/* sv/tilt_angle_rep_counter_core.sv */
`timescale 1ns / 1ps
// from the input transfer: S_CALC while the rotator iterates, r_fin, r_done, S_WRAP, then o_out_valid
// one item at a time through the shared arctangent rotator; S_WRAP waits for a free output slot
// o_in_ready is high only while no item is in flight; a finished result may wait in the output register
// reset (synchronous, active low): thresholds to 350 / 700 / 150, angle, phase, reps and sequence to zero

module tilt_angle_rep_counter_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // sample channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic signed [tarc_pkg::ACC_IN_W-1:0] i_accel_y,
    input  logic signed [tarc_pkg::ACC_IN_W-1:0] i_accel_z,
    input  logic                            i_read_ok,
    input  logic [tarc_pkg::FORCE_W-1:0]    i_force_raw,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [tarc_pkg::ANGLE_W-1:0]    o_angle_tenths,
    output logic [tarc_pkg::FORCE_W-1:0]    o_force_value,
    output logic                            o_motor_on,
    output logic [tarc_pkg::REP_W-1:0]      o_rep_count,
    output logic [tarc_pkg::SEQ_W-1:0]      o_sequence_res,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [tarc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tarc_pkg::CFG_DAT_W-1:0]  i_cfg_data
);
    import tarc_pkg::*;

    t_state r_state, n_state;

    // configuration registers
    logic [THR_A_W-1:0] r_low_thr, r_high_thr;
    logic [FORCE_W-1:0] r_force_thr;

    // architectural state
    logic [ANGLE_W-1:0] r_last_angle, n_last_angle;
    logic               r_ext, n_ext;
    logic [REP_W-1:0]   r_reps, n_reps;
    logic [SEQ_W-1:0]   r_seq, n_seq;

    // captured sample fields
    logic               r_read_ok;
    logic [FORCE_W-1:0] r_force;

    // output register
    logic               r_out_valid;
    logic [ANGLE_W-1:0] r_o_angle;
    logic [FORCE_W-1:0] r_o_force;
    logic               r_o_motor;
    logic [REP_W-1:0]   r_o_reps;
    logic [SEQ_W-1:0]   r_o_seq;

    logic               w_in_xfer, w_out_xfer, w_commit, w_slot_free;
    logic [ACC_IN_W-1:0] w_mag_y, w_mag_z;
    logic               w_cdc_done;
    logic [ANGLE_W-1:0] w_cdc_angle;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_out_xfer = r_out_valid && i_out_ready;
    // the output slot is free when empty or being drained this cycle
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_commit    = (r_state == S_WRAP) && w_slot_free;

    // magnitudes; the most negative reading maps to 32768 exactly
    assign w_mag_y = i_accel_y[ACC_IN_W-1] ? ACC_IN_W'(~i_accel_y + 1'b1) : i_accel_y;
    assign w_mag_z = i_accel_z[ACC_IN_W-1] ? ACC_IN_W'(~i_accel_z + 1'b1) : i_accel_z;

    // shared arctangent rotator, started on every sample transfer
    tarc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_xfer),
        .i_mag_y (w_mag_y),
        .i_mag_z (w_mag_z),
        .o_done  (w_cdc_done),
        .o_angle (w_cdc_angle)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_in_xfer) n_state = S_CALC;
            S_CALC:  if (w_cdc_done) n_state = S_WRAP;
            S_WRAP:  if (w_slot_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // angle selection, hysteresis and counters for the committing sample
    always_comb begin
        n_last_angle = r_read_ok ? w_cdc_angle : r_last_angle;
        n_ext        = r_ext;
        n_reps       = r_reps;
        if (!r_ext) begin
            // ready knee extends at or above the high threshold
            if (THR_A_W'(n_last_angle) >= r_high_thr) begin
                n_ext = 1'b1;
            end
        end else if (THR_A_W'(n_last_angle) <= r_low_thr) begin
            // rep completes, counter saturates
            if (r_reps != '1) begin
                n_reps = r_reps + 1'b1;
            end
            n_ext = 1'b0;
        end
        n_seq = r_seq + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_low_thr    <= RST_LOW_ANGLE;
            r_high_thr   <= RST_HIGH_ANGLE;
            r_force_thr  <= RST_FORCE_THR;
            r_last_angle <= '0;
            r_ext        <= 1'b0;
            r_reps       <= '0;
            r_seq        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_LOW_ANGLE:  r_low_thr   <= i_cfg_data[THR_A_W-1:0];
                    REG_HIGH_ANGLE: r_high_thr  <= i_cfg_data[THR_A_W-1:0];
                    REG_FORCE_THR:  r_force_thr <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_commit) begin
                r_last_angle <= n_last_angle;
                r_ext        <= n_ext;
                r_reps       <= n_reps;
                r_seq        <= n_seq;
                r_out_valid  <= 1'b1;
            end else if (w_out_xfer) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_read_ok <= i_read_ok;
            r_force   <= i_force_raw;
        end
        if (w_commit) begin
            r_o_angle <= n_last_angle;
            r_o_force <= r_force;
            r_o_motor <= (r_force >= r_force_thr);
            r_o_reps  <= n_reps;
            r_o_seq   <= n_seq;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_angle_tenths = r_o_angle;
    assign o_force_value  = r_o_force;
    assign o_motor_on     = r_o_motor;
    assign o_rep_count    = r_o_reps;
    assign o_sequence_res = r_o_seq;

endmodule

/* sv/tarc_cordic.sv */
`timescale 1ns / 1ps

module tarc_cordic (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [tarc_pkg::ACC_IN_W-1:0]   i_mag_y,
    input  logic [tarc_pkg::ACC_IN_W-1:0]   i_mag_z,
    output logic                            o_done,
    output logic [tarc_pkg::ANGLE_W-1:0]    o_angle
);
    import tarc_pkg::*;

    logic signed [XY_W-1:0]  r_x, r_y, n_x, n_y;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic [ITER_W-1:0]       r_iter;
    logic                    r_busy, r_fin, r_done;
    logic                    r_y_zero, r_z_zero;
    logic [ANGLE_W-1:0]      r_angle, n_angle;

    logic signed [XY_W-1:0]  w_sx, w_sy;
    logic signed [ACC_W-1:0] w_atan, w_rnd;
    logic [11:0]             w_whole;

    // one vectoring micro-rotation per cycle
    always_comb begin
        w_sx   = r_x >>> r_iter;
        w_sy   = r_y >>> r_iter;
        w_atan = tarc_atan(TBL_W'(r_iter));
        if (r_y > 0) begin
            n_x   = r_x + w_sy;
            n_y   = r_y - w_sx;
            n_acc = r_acc + w_atan;
        end else begin
            n_x   = r_x - w_sy;
            n_y   = r_y + w_sx;
            n_acc = r_acc - w_atan;
        end
    end

    // round half up to whole tenths and clamp
    always_comb begin
        w_rnd   = r_acc + ACC_W'(32768);
        w_whole = w_rnd[27:16];
        if (r_y_zero) begin
            n_angle = '0;
        end else if (r_z_zero) begin
            n_angle = ANGLE_MAX;
        end else if (r_acc <= 0) begin
            n_angle = '0;
        end else if (w_whole > 12'(ANGLE_MAX)) begin
            n_angle = ANGLE_MAX;
        end else begin
            n_angle = w_whole[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
            end else if (r_busy) begin
                r_iter <= r_iter + 1'b1;
                if (r_iter == ITER_W'(TARC_ITERS - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x      <= $signed({3'b000, i_mag_z, 14'd0});
            r_y      <= $signed({3'b000, i_mag_y, 14'd0});
            r_acc    <= '0;
            r_y_zero <= (i_mag_y == '0);
            r_z_zero <= (i_mag_z == '0);
        end else if (r_busy) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_acc <= n_acc;
        end
        if (r_fin) begin
            r_angle <= n_angle;
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_angle;

endmodule

/* sim/tarc_result_checker.sv */
`timescale 1ns / 1ps

module tarc_result_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_ready,
    input  logic signed [tarc_pkg::ACC_IN_W-1:0] i_accel_y,
    input  logic signed [tarc_pkg::ACC_IN_W-1:0] i_accel_z,
    input  logic                                 i_read_ok,
    input  logic [tarc_pkg::FORCE_W-1:0]         i_force_raw,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_ready,
    input  logic [tarc_pkg::ANGLE_W-1:0]         i_angle_tenths,
    input  logic [tarc_pkg::FORCE_W-1:0]         i_force_value,
    input  logic                                 i_motor_on,
    input  logic [tarc_pkg::REP_W-1:0]           i_rep_count,
    input  logic [tarc_pkg::SEQ_W-1:0]           i_sequence_res,
    input  logic                                 i_cfg_we,
    input  logic [tarc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tarc_pkg::CFG_DAT_W-1:0]       i_cfg_data,
    output int                                   o_fail_count,
    output int                                   o_pending
);

    typedef struct packed {
        logic [tarc_pkg::ANGLE_W-1:0] angle;
        logic [tarc_pkg::FORCE_W-1:0] force_val;
        logic                         motor;
        logic [tarc_pkg::REP_W-1:0]   reps;
        logic [tarc_pkg::SEQ_W-1:0]   seq;
    } t_knee_result;

    // atan(2^-i) in tenths of a degree, q16
    longint atan_step [24] = '{
        29491200, 17409672, 9198793, 4669451, 2343786, 1173036, 586661, 293348,
        146676, 73339, 36669, 18335, 9167, 4584, 2292, 1146,
        573, 286, 143, 72, 36, 18, 9, 4
    };

    logic [tarc_pkg::THR_A_W-1:0] low_thr;
    logic [tarc_pkg::THR_A_W-1:0] high_thr;
    logic [tarc_pkg::FORCE_W-1:0] motor_thr;
    logic [tarc_pkg::ANGLE_W-1:0] held_angle;
    logic                         extended;
    logic [tarc_pkg::REP_W-1:0]   reps_done;
    logic [tarc_pkg::SEQ_W-1:0]   sample_seq;
    t_knee_result                 results_due [$];

    initial o_fail_count = 0;
    initial o_pending = 0;

    function automatic longint magnitude(input logic signed [tarc_pkg::ACC_IN_W-1:0] v);
        longint w;
        w = longint'(v);
        return (w < 0) ? -w : w;
    endfunction

    // vectoring rotation toward the x axis, angle accumulated in q16 tenths
    function automatic logic [tarc_pkg::ANGLE_W-1:0] tilt_tenths(input longint mag_y,
                                                                 input longint mag_z);
        longint xr;
        longint yr;
        longint xn;
        longint acc;
        acc = 0;
        if (mag_y == 0) return '0;
        if (mag_z == 0) return tarc_pkg::ANGLE_MAX;
        xr = mag_z <<< tarc_pkg::PRE_SHIFT;
        yr = mag_y <<< tarc_pkg::PRE_SHIFT;
        for (int i = 0; i < tarc_pkg::TARC_ITERS; i++) begin
            if (yr > 0) begin
                xn = xr + (yr >>> i);
                yr = yr - (xr >>> i);
                acc += atan_step[i];
            end else begin
                xn = xr - (yr >>> i);
                yr = yr + (xr >>> i);
                acc -= atan_step[i];
            end
            xr = xn;
        end
        if (acc <= 0) return '0;
        acc = (acc + 32768) >>> 16;
        return (acc > 900) ? tarc_pkg::ANGLE_MAX : tarc_pkg::ANGLE_W'(acc);
    endfunction

    // one sample through angle hold, hysteresis and counters
    function automatic t_knee_result advance_knee(
        input logic signed [tarc_pkg::ACC_IN_W-1:0] ay,
        input logic signed [tarc_pkg::ACC_IN_W-1:0] az,
        input logic                                 ok,
        input logic [tarc_pkg::FORCE_W-1:0]         frc
    );
        t_knee_result r;
        if (ok) held_angle = tilt_tenths(magnitude(ay), magnitude(az));
        if (!extended) begin
            if (tarc_pkg::THR_A_W'(held_angle) >= high_thr) extended = 1'b1;
        end else if (tarc_pkg::THR_A_W'(held_angle) <= low_thr) begin
            if (reps_done != '1) reps_done = reps_done + 1'b1;
            extended = 1'b0;
        end
        sample_seq = sample_seq + 1'b1;
        r.angle     = held_angle;
        r.force_val = frc;
        r.motor     = (frc >= motor_thr);
        r.reps      = reps_done;
        r.seq       = sample_seq;
        return r;
    endfunction

    function automatic int field_differs(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        int errs;
        t_knee_result want;
        errs = 0;
        if (!i_rst_n) begin
            low_thr    = tarc_pkg::RST_LOW_ANGLE;
            high_thr   = tarc_pkg::RST_HIGH_ANGLE;
            motor_thr  = tarc_pkg::RST_FORCE_THR;
            held_angle = '0;
            extended   = 1'b0;
            reps_done  = '0;
            sample_seq = '0;
            results_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tarc_pkg::REG_LOW_ANGLE:  low_thr = i_cfg_data[tarc_pkg::THR_A_W-1:0];
                    tarc_pkg::REG_HIGH_ANGLE: high_thr = i_cfg_data[tarc_pkg::THR_A_W-1:0];
                    tarc_pkg::REG_FORCE_THR:  motor_thr = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result transfer with nothing expected, angle %0d seq %0d",
                             $time, i_angle_tenths, i_sequence_res);
                    errs++;
                end else begin
                    want = results_due.pop_front();
                    errs += field_differs("angle_tenths", 32'(want.angle),
                                          32'(i_angle_tenths));
                    errs += field_differs("force_value", 32'(want.force_val),
                                          32'(i_force_value));
                    errs += field_differs("motor_on", 32'(want.motor), 32'(i_motor_on));
                    errs += field_differs("rep_count", 32'(want.reps), 32'(i_rep_count));
                    errs += field_differs("sequence_res", want.seq, i_sequence_res);
                end
            end
            if (i_in_valid && i_in_ready)
                results_due.push_back(advance_knee(i_accel_y, i_accel_z, i_read_ok,
                                                   i_force_raw));
        end
        o_pending    <= results_due.size();
        o_fail_count <= o_fail_count + errs;
    end

endmodule

/* sim/tilt_angle_rep_counter_core_tb.sv */
`timescale 1ns / 1ps

module tilt_angle_rep_counter_core_tb;

    // index past the last register, writes there must change nothing
    localparam logic [tarc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int SAMPLES_PER_PHASE = 50;
    localparam int PHASES            = 11;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // sample channel
    logic                                 in_valid  = 1'b0;
    logic                                 in_ready;
    logic signed [tarc_pkg::ACC_IN_W-1:0] accel_y   = '0;
    logic signed [tarc_pkg::ACC_IN_W-1:0] accel_z   = '0;
    logic                                 read_ok   = 1'b0;
    logic [tarc_pkg::FORCE_W-1:0]         force_raw = '0;

    // result channel
    logic                                 out_valid;
    logic                                 out_ready = 1'b0;
    logic [tarc_pkg::ANGLE_W-1:0]         angle_tenths;
    logic [tarc_pkg::FORCE_W-1:0]         force_value;
    logic                                 motor_on;
    logic [tarc_pkg::REP_W-1:0]           rep_count;
    logic [tarc_pkg::SEQ_W-1:0]           sequence_res;

    // register write port
    logic                                 cfg_we   = 1'b0;
    logic [tarc_pkg::CFG_IDX_W-1:0]       cfg_idx  = '0;
    logic [tarc_pkg::CFG_DAT_W-1:0]       cfg_data = '0;

    int fail_count;
    int pending;

    // random gaps on/off, switched per phase so some stretches run back to back
    bit idle_mode  = 1'b1;
    bit stall_mode = 1'b1;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    tilt_angle_rep_counter_core u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_accel_y      (accel_y),
        .i_accel_z      (accel_z),
        .i_read_ok      (read_ok),
        .i_force_raw    (force_raw),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_angle_tenths (angle_tenths),
        .o_force_value  (force_value),
        .o_motor_on     (motor_on),
        .o_rep_count    (rep_count),
        .o_sequence_res (sequence_res),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data)
    );

    tarc_result_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_accel_y      (accel_y),
        .i_accel_z      (accel_z),
        .i_read_ok      (read_ok),
        .i_force_raw    (force_raw),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_angle_tenths (angle_tenths),
        .i_force_value  (force_value),
        .i_motor_on     (motor_on),
        .i_rep_count    (rep_count),
        .i_sequence_res (sequence_res),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // one sample transfer; entered and left on a rising edge
    task automatic send_sample(input logic signed [tarc_pkg::ACC_IN_W-1:0] ay,
                               input logic signed [tarc_pkg::ACC_IN_W-1:0] az,
                               input logic ok,
                               input logic [tarc_pkg::FORCE_W-1:0] frc);
        int gap;
        gap = idle_mode ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        accel_y   <= ay;
        accel_z   <= az;
        read_ok   <= ok;
        force_raw <= frc;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // drop valid, let every expected result drain, then a few quiet cycles
    task automatic wait_idle(input int settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // back-to-back writes of all registers plus one to the unused index
    task automatic program_thresholds(input logic [tarc_pkg::CFG_DAT_W-1:0] lo,
                                      input logic [tarc_pkg::CFG_DAT_W-1:0] hi,
                                      input logic [tarc_pkg::CFG_DAT_W-1:0] fthr);
        cfg_we   <= 1'b1;
        cfg_idx  <= tarc_pkg::REG_LOW_ANGLE;
        cfg_data <= lo;
        @(posedge clk);
        cfg_idx  <= tarc_pkg::REG_HIGH_ANGLE;
        cfg_data <= hi;
        @(posedge clk);
        cfg_idx  <= tarc_pkg::REG_FORCE_THR;
        cfg_data <= fthr;
        @(posedge clk);
        cfg_idx  <= REG_SPARE;
        cfg_data <= tarc_pkg::CFG_DAT_W'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [tarc_pkg::ACC_IN_W-1:0] corner_reading();
        case ($urandom_range(0, 4))
            0:       return 16'sd0;
            1:       return 16'sd1;
            2:       return -16'sd1;
            3:       return 16'sh7FFF;
            default: return 16'sh8000;
        endcase
    endfunction

    // result side: per result a random stall, sometimes only once the result shows
    initial begin
        int gap;
        repeat (6) @(posedge clk);
        forever begin
            gap = stall_mode ? $urandom_range(0, 10) : 0;
            if (gap > 0) begin
                out_ready <= 1'b0;
                if ($urandom_range(0, 1)) begin
                    @(posedge clk);
                    while (!out_valid) @(posedge clk);
                end
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial begin
        logic [tarc_pkg::CFG_DAT_W-1:0]       lo;
        logic [tarc_pkg::CFG_DAT_W-1:0]       hi;
        logic [tarc_pkg::CFG_DAT_W-1:0]       fthr;
        logic [tarc_pkg::FORCE_W-1:0]         frc;
        logic signed [tarc_pkg::ACC_IN_W-1:0] sy;
        logic signed [tarc_pkg::ACC_IN_W-1:0] sz;
        int  big;
        int  tiny;
        int  kind;
        bit  go_high;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset thresholds 350 / 700 / 150 in force here
        send_sample(16'sd0, 16'sd0, 1'b1, 12'd0);          // both readings zero
        send_sample(16'sd0, 16'sh8000, 1'b1, 12'd149);     // y zero, z most negative
        send_sample(16'sd1000, 16'sd0, 1'b1, 12'd150);     // z zero: straight up, extends
        send_sample(16'sh8000, 16'sd12345, 1'b0, 12'hFFF); // failed read holds 900
        send_sample(16'sd0, 16'sd5000, 1'b1, 12'd151);     // back down: rep completes
        send_sample(16'sh8000, 16'sh8000, 1'b1, 12'd2048); // both most negative
        send_sample(16'sh7FFF, 16'sd1, 1'b1, 12'd1);
        send_sample(16'sd1, 16'sh7FFF, 1'b1, 12'd4094);
        send_sample(-16'sd1, -16'sd1, 1'b1, 12'd150);
        send_sample(16'sh8000, 16'sh7FFF, 1'b1, 12'd700);
        send_sample(16'sd100, -16'sd173, 1'b1, 12'd300);
        send_sample(-16'sd173, 16'sd100, 1'b1, 12'd900);
        send_sample(16'sd12000, 16'sd3000, 1'b1, 12'd55);
        send_sample(16'sh7FFF, 16'sh8000, 1'b0, 12'hAAA);  // failed read, held angle
        send_sample(-16'sd2000, 16'sh7FFF, 1'b1, 12'h555);
        send_sample(16'sh5555, -16'sh2AAB, 1'b0, 12'd149);

        go_high = 1'b1;
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle(8);
            case (phase)
                0: begin lo = 12'd350;  hi = 12'd700;  fthr = 12'd150;  end
                1: begin lo = 12'd0;    hi = 12'd0;    fthr = 12'd0;    end
                // angle registers keep 11 bits: an extended knee completes on the next sample, then never extends again
                2: begin lo = 12'hFFF;  hi = 12'hFFF;  fthr = 12'hFFF;  end
                3: begin lo = 12'd900;  hi = 12'd900;  fthr = 12'd2048; end
                4: begin lo = 12'd1000; hi = 12'd1800; fthr = 12'd1;    end
                5: begin lo = 12'd0;    hi = 12'd900;  fthr = 12'd4094; end
                // extends and completes on alternate samples
                6: begin lo = 12'd1800; hi = 12'd0;    fthr = 12'($urandom); end
                default: begin
                    lo   = 12'($urandom_range(100, 600));
                    hi   = 12'($urandom_range(lo, 880));
                    fthr = 12'($urandom);
                end
            endcase
            program_thresholds(lo, hi, fthr);
            idle_mode  = (phase % 4 != 1);
            stall_mode = (phase % 3 != 2);

            for (int n = 0; n < SAMPLES_PER_PHASE; n++) begin
                // mostly alternating steep / flat tilts so the rep machine cycles
                if ($urandom_range(0, 2) == 0) go_high = !go_high;
                kind = $urandom_range(0, 9);
                sy   = 16'($urandom);
                sz   = 16'($urandom);
                if (kind < 7) begin
                    big  = $urandom_range(4000, 32767);
                    tiny = $urandom_range(0, 2500);
                    sy   = go_high ? 16'(big) : 16'(tiny);
                    sz   = go_high ? 16'(tiny) : 16'(big);
                    if ($urandom_range(0, 1)) sy = -sy;
                    if ($urandom_range(0, 1)) sz = -sz;
                end else if (kind == 7) begin
                    sy = corner_reading();
                    sz = corner_reading();
                end
                case ($urandom_range(0, 5))
                    0:       frc = fthr;
                    1:       frc = fthr - 1'b1;
                    default: frc = 12'($urandom);
                endcase
                send_sample(sy, sz, $urandom_range(0, 7) != 0, frc);
            end
        end

        wait_idle(40);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // hang guard, several times the slowest legal run
    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
